// ----- design/kpe_pkg.sv -----
// Package for the keypad PIN entry controller: controller states, event and
// reply codes, key characters, and the state and result records.
// No dependencies; every design file imports it.
`default_nettype none

package kpe_pkg;

    // Width of the digit counters; holds a full entry of up to eight digits
    localparam int CNT_W = 4;

    // Controller modes, encoded as reported on ctrl_state
    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_LOGIN     = 4'd1,
        ST_AUTH_WAIT = 4'd2,
        ST_AUTH_OK   = 4'd3,
        ST_AUTH_FAIL = 4'd4,
        ST_REG       = 4'd5,
        ST_REG_WAIT  = 4'd6,
        ST_REG_OK    = 4'd7,
        ST_REG_FAIL  = 4'd8
    } mode_t;

    // Event kinds carried on the command field
    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Decoded server replies
    localparam logic [2:0] RPL_AUTH_OK  = 3'd0;
    localparam logic [2:0] RPL_AUTH_BAD = 3'd1;
    localparam logic [2:0] RPL_REG_OK   = 3'd2;
    localparam logic [2:0] RPL_REG_BAD  = 3'd3;

    // Request kinds reported on request_sent
    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_AUTH = 2'd1;
    localparam logic [1:0] REQ_REG  = 2'd2;

    // Key characters
    localparam logic [7:0] KEY_NONE = 8'h00;
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;

    // Register map (word index on the configuration port)
    localparam logic REG_SERVER_TIMEOUT = 1'b0;
    localparam logic REG_RESULT_HOLD    = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] HOLD_RESET    = 16'd3000;

    typedef struct packed {
        logic [15:0] server_timeout_ticks;
        logic [15:0] result_hold_ticks;
    } kpe_cfg_t;

    typedef struct packed {
        mode_t            mode;
        logic             pin_phase;
        logic [15:0]      locker_store;
        logic [CNT_W-1:0] locker_len;
        logic [15:0]      pin_store;
        logic [CNT_W-1:0] pin_len;
        logic [7:0]       last_key;
        logic [15:0]      elapsed_ticks;
    } kpe_state_t;

    typedef struct packed {
        logic [3:0]  ctrl_state;
        logic        entering_pin;
        logic [15:0] locker_digits;
        logic [2:0]  locker_count;
        logic [15:0] pin_digits;
        logic [2:0]  pin_count;
        logic [1:0]  request_sent;
        logic        pin_short_warning;
        logic        timed_out;
    } kpe_result_t;

endpackage

`default_nettype wire

// ----- design/keypad_pin_entry_controller.sv -----
// Keypad PIN entry controller top level: state and result registers around
// the event logic. Depends on kpe_pkg, kpe_cfg_regs and kpe_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per beat: a keypad
//   level sample, a decoded server reply or a one millisecond tick.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   event, showing the controller state after that event plus the request,
//   short-PIN warning and timeout flags raised by it.
//   The event is evaluated in the accepting cycle and its result sits in
//   the output register from the next cycle on.
//   Throughput is one event per clock while in_ready is high; in_ready
//   stays high while the output register is empty or being taken.
//   When the receiver stalls, the result is held and further events are
//   refused until the beat goes out.
//   Reset brings the controller to idle with an empty entry, both timers
//   registers to 3000 ticks, and the output register empty.
//   Registers (APB, word addressed): 0x0 server timeout ticks,
//   0x4 result hold ticks; write only while the block is idle.
`default_nettype none

module keypad_pin_entry_controller #(
    parameter int LOCKER_DIGITS = 4,
    parameter int PIN_DIGITS    = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Event channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  key_code,
    input  wire logic [2:0]  reply_code,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       ctrl_state,
    output logic             entering_pin,
    output logic [15:0]      locker_digits,
    output logic [2:0]       locker_count,
    output logic [15:0]      pin_digits,
    output logic [2:0]       pin_count,
    output logic [1:0]       request_sent,
    output logic             pin_short_warning,
    output logic             timed_out,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import kpe_pkg::*;

    kpe_cfg_t    cfg;
    kpe_state_t  state_reg;
    kpe_state_t  state_next;
    kpe_result_t res_reg;
    kpe_result_t res_next;
    logic        out_valid_reg;
    logic        accept;

    assign pready = 1'b1;

    kpe_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    kpe_step #(
        .LOCKER_DIGITS (LOCKER_DIGITS),
        .PIN_DIGITS    (PIN_DIGITS)
    ) u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .command    (command),
        .key_code   (key_code),
        .reply_code (reply_code),
        .nxt        (state_next),
        .res        (res_next)
    );

    // Take a beat whenever the output register frees up this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Advance controller state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: ST_IDLE, default: '0};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign ctrl_state        = res_reg.ctrl_state;
    assign entering_pin      = res_reg.entering_pin;
    assign locker_digits     = res_reg.locker_digits;
    assign locker_count      = res_reg.locker_count;
    assign pin_digits        = res_reg.pin_digits;
    assign pin_count         = res_reg.pin_count;
    assign request_sent      = res_reg.request_sent;
    assign pin_short_warning = res_reg.pin_short_warning;
    assign timed_out         = res_reg.timed_out;

endmodule

`default_nettype wire

// ----- design/kpe_cfg_regs.sv -----
// Configuration registers of the keypad PIN entry controller behind an
// APB-style port. Depends on kpe_pkg.
`default_nettype none

module kpe_cfg_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output kpe_pkg::kpe_cfg_t     cfg
);
    import kpe_pkg::*;

    logic [15:0] timeout_reg;
    logic [15:0] hold_reg;
    logic        wr_en;
    logic        sel_idx;

    // Word select ignores the byte offset
    assign sel_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            hold_reg    <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel_idx)
                REG_SERVER_TIMEOUT: timeout_reg <= pwdata[15:0];
                REG_RESULT_HOLD:    hold_reg    <= pwdata[15:0];
                default:            timeout_reg <= timeout_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (sel_idx)
            REG_SERVER_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_RESULT_HOLD:    prdata = {16'd0, hold_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.server_timeout_ticks = timeout_reg;
    assign cfg.result_hold_ticks    = hold_reg;

endmodule

`default_nettype wire

// ----- design/kpe_step.sv -----
// Next-state and result logic for one event of the keypad PIN entry
// controller. Purely combinational. Depends on kpe_pkg.
`default_nettype none

module kpe_step #(
    parameter int LOCKER_DIGITS = 4,
    parameter int PIN_DIGITS    = 4
) (
    input  kpe_pkg::kpe_state_t  cur,
    input  kpe_pkg::kpe_cfg_t    cfg,
    input  wire logic [1:0]      command,
    input  wire logic [7:0]      key_code,
    input  wire logic [2:0]      reply_code,
    output kpe_pkg::kpe_state_t  nxt,
    output kpe_pkg::kpe_result_t res
);
    import kpe_pkg::*;

    localparam logic [CNT_W-1:0] LOCKER_MAX = CNT_W'(LOCKER_DIGITS);
    localparam logic [CNT_W-1:0] PIN_MAX    = CNT_W'(PIN_DIGITS);

    // Place a digit in its nibble, first digit highest; positions past four drop
    function automatic logic [15:0] put_digit(
        input logic [15:0]      store,
        input logic [CNT_W-1:0] pos,
        input logic [3:0]       digit
    );
        logic [15:0] r;
        r = store;
        if (pos < CNT_W'(4))
        begin
            case (pos[1:0])
                2'd0:    r = store | {digit, 12'd0};
                2'd1:    r = store | {4'd0, digit, 8'd0};
                2'd2:    r = store | {8'd0, digit, 4'd0};
                default: r = store | {12'd0, digit};
            endcase
        end
        return r;
    endfunction

    logic        waiting;
    logic        holding;
    logic        key_rise;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] ticks_inc;
    logic [1:0]  req;
    logic        warn;
    logic        tmo;

    assign waiting   = (cur.mode == ST_AUTH_WAIT) || (cur.mode == ST_REG_WAIT);
    assign holding   = (cur.mode == ST_AUTH_OK) || (cur.mode == ST_AUTH_FAIL) ||
                       (cur.mode == ST_REG_OK) || (cur.mode == ST_REG_FAIL);
    assign key_rise  = (key_code != KEY_NONE) && (cur.last_key == KEY_NONE);
    assign is_digit  = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
    assign digit     = 4'(key_code - KEY_ZERO);
    // Saturating tick count
    assign ticks_inc = (cur.elapsed_ticks == 16'hFFFF) ? cur.elapsed_ticks
                                                       : cur.elapsed_ticks + 16'd1;

    // Update the controller for one event
    always_comb
    begin
        nxt  = cur;
        req  = REQ_NONE;
        warn = 1'b0;
        tmo  = 1'b0;
        unique case (command)
            CMD_KEY:
            begin
                if (!waiting && !holding)
                begin
                    nxt.last_key = key_code;
                    if (key_rise)
                    begin
                        if (cur.mode == ST_IDLE)
                        begin
                            if (key_code == KEY_STAR || key_code == KEY_HASH)
                            begin
                                nxt.mode         = (key_code == KEY_STAR) ? ST_LOGIN : ST_REG;
                                nxt.pin_phase    = 1'b0;
                                nxt.locker_store = 16'd0;
                                nxt.locker_len   = '0;
                                nxt.pin_store    = 16'd0;
                                nxt.pin_len      = '0;
                            end
                        end
                        else if (is_digit)
                        begin
                            // Fill the active field until it is full
                            if (!cur.pin_phase)
                            begin
                                if (cur.locker_len < LOCKER_MAX)
                                begin
                                    nxt.locker_store = put_digit(cur.locker_store,
                                                                 cur.locker_len, digit);
                                    nxt.locker_len   = cur.locker_len + CNT_W'(1);
                                end
                            end
                            else if (cur.pin_len < PIN_MAX)
                            begin
                                nxt.pin_store = put_digit(cur.pin_store, cur.pin_len, digit);
                                nxt.pin_len   = cur.pin_len + CNT_W'(1);
                            end
                        end
                        else if (key_code == KEY_HASH)
                        begin
                            // Confirm: advance to the PIN, send the request, or warn of a short PIN
                            if (!cur.pin_phase)
                            begin
                                if (cur.locker_len != '0)
                                    nxt.pin_phase = 1'b1;
                            end
                            else if (cur.pin_len == PIN_MAX)
                            begin
                                if (cur.mode == ST_LOGIN)
                                begin
                                    nxt.mode = ST_AUTH_WAIT;
                                    req      = REQ_AUTH;
                                end
                                else
                                begin
                                    nxt.mode = ST_REG_WAIT;
                                    req      = REQ_REG;
                                end
                                nxt.elapsed_ticks = 16'd0;
                            end
                            else
                            begin
                                warn = 1'b1;
                            end
                        end
                        else if (key_code == KEY_STAR)
                        begin
                            // Drop the whole entry
                            nxt.pin_phase    = 1'b0;
                            nxt.locker_store = 16'd0;
                            nxt.locker_len   = '0;
                            nxt.pin_store    = 16'd0;
                            nxt.pin_len      = '0;
                        end
                    end
                end
            end
            CMD_REPLY:
            begin
                if (cur.mode == ST_AUTH_WAIT &&
                    (reply_code == RPL_AUTH_OK || reply_code == RPL_AUTH_BAD))
                begin
                    nxt.mode = (reply_code == RPL_AUTH_OK) ? ST_AUTH_OK : ST_AUTH_FAIL;
                    nxt.elapsed_ticks = 16'd0;
                end
                else if (cur.mode == ST_REG_WAIT &&
                         (reply_code == RPL_REG_OK || reply_code == RPL_REG_BAD))
                begin
                    nxt.mode = (reply_code == RPL_REG_OK) ? ST_REG_OK : ST_REG_FAIL;
                    nxt.elapsed_ticks = 16'd0;
                end
            end
            CMD_TICK:
            begin
                if (waiting || holding)
                begin
                    nxt.elapsed_ticks = ticks_inc;
                    if (waiting && ticks_inc >= cfg.server_timeout_ticks)
                    begin
                        nxt.mode = (cur.mode == ST_AUTH_WAIT) ? ST_AUTH_FAIL : ST_REG_FAIL;
                        nxt.elapsed_ticks = 16'd0;
                        tmo = 1'b1;
                    end
                    else if (holding && ticks_inc >= cfg.result_hold_ticks)
                    begin
                        nxt.mode          = ST_IDLE;
                        nxt.elapsed_ticks = 16'd0;
                        nxt.pin_phase     = 1'b0;
                        nxt.locker_store  = 16'd0;
                        nxt.locker_len    = '0;
                        nxt.pin_store     = 16'd0;
                        nxt.pin_len       = '0;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Report the state after the event
    always_comb
    begin
        res.ctrl_state        = nxt.mode;
        res.entering_pin      = nxt.pin_phase;
        res.locker_digits     = nxt.locker_store;
        res.locker_count      = nxt.locker_len[2:0];
        res.pin_digits        = nxt.pin_store;
        res.pin_count         = nxt.pin_len[2:0];
        res.request_sent      = req;
        res.pin_short_warning = warn;
        res.timed_out         = tmo;
    end

endmodule

`default_nettype wire
